// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on clk, off while rst_n is low
`define C2P_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// concurrent assertion sampled on clk, active during reset too
`define C2P_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/c2p_pkg.sv =====
// types, constants and arctangent table for the rectangular to polar converter
package c2p_pkg;

    localparam int unsigned COORD_W     = 16;
    localparam int unsigned FRAC_W      = 40 - COORD_W;
    localparam int unsigned DATA_W      = COORD_W + FRAC_W + 3;
    localparam int unsigned ANGLE_ACC_W = 24;
    localparam int unsigned QUAD_W      = 3;
    localparam int unsigned RADIUS_W    = 16;
    localparam int unsigned ANGLE_W     = 16;
    localparam int unsigned GAIN_W      = 24;
    localparam int unsigned ATAN_ENTRIES = 32;

    localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10188014;
    localparam int QUARTER_FINE = 90 * 32768;
    localparam int HALF_TURN    = 180 * 128;

    typedef enum logic [QUAD_W-1:0] {
        QUAD_AXIS = 3'd0,
        QUAD_1    = 3'd1,
        QUAD_2    = 3'd2,
        QUAD_3    = 3'd3,
        QUAD_4    = 3'd4
    } c2p_quad_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
    } c2p_in_t;

    typedef struct packed {
        logic [QUAD_W-1:0]          quadrant;
        logic [RADIUS_W-1:0]        radius;
        logic signed [ANGLE_W-1:0]  angle_deg;
    } c2p_out_t;

    // point facts carried alongside the rotation
    typedef struct packed {
        c2p_quad_t quad;
        logic      x_zero;
        logic      y_zero;
        logic      x_neg;
        logic      y_neg;
    } c2p_side_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]      cx;
        logic signed [DATA_W-1:0]      cy;
        logic signed [ANGLE_ACC_W-1:0] z;
        c2p_side_t                     side;
    } c2p_vec_t;

    // atan(2^-i) in units of 1/32768 degree
    function automatic logic signed [ANGLE_ACC_W-1:0] c2p_atan(input int unsigned idx);
        logic signed [ANGLE_ACC_W-1:0] t;
        begin
            case (idx)
                0:  t = 24'sd1474560;
                1:  t = 24'sd870484;
                2:  t = 24'sd459940;
                3:  t = 24'sd233473;
                4:  t = 24'sd117189;
                5:  t = 24'sd58652;
                6:  t = 24'sd29333;
                7:  t = 24'sd14667;
                8:  t = 24'sd7334;
                9:  t = 24'sd3667;
                10: t = 24'sd1833;
                11: t = 24'sd917;
                12: t = 24'sd458;
                13: t = 24'sd229;
                14: t = 24'sd115;
                15: t = 24'sd57;
                16: t = 24'sd29;
                17: t = 24'sd14;
                18: t = 24'sd7;
                19: t = 24'sd4;
                20: t = 24'sd2;
                21: t = 24'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

// ===== hw/rtl/c2p_prep.sv =====
// input stage: magnitudes, quadrant and axis flags
module c2p_prep (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  c2p_pkg::c2p_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output c2p_pkg::c2p_vec_t  out_data
);
    import c2p_pkg::*;

    localparam int unsigned PAD_W = DATA_W - COORD_W - 1 - FRAC_W;

    logic              valid_reg;
    c2p_vec_t          data_reg;
    c2p_vec_t          data_next;
    logic signed [COORD_W:0] x_ext;
    logic signed [COORD_W:0] y_ext;
    logic [COORD_W:0]  ax;
    logic [COORD_W:0]  ay;
    c2p_side_t         side;

    always_comb begin
        x_ext = {in_data.coord_x[COORD_W-1], in_data.coord_x};
        y_ext = {in_data.coord_y[COORD_W-1], in_data.coord_y};
        side.x_neg  = in_data.coord_x[COORD_W-1];
        side.y_neg  = in_data.coord_y[COORD_W-1];
        side.x_zero = (in_data.coord_x == '0);
        side.y_zero = (in_data.coord_y == '0);
        ax = side.x_neg ? -x_ext : x_ext;
        ay = side.y_neg ? -y_ext : y_ext;
        priority if (side.x_zero || side.y_zero) begin
            side.quad = QUAD_AXIS;
        end else if (!side.x_neg && !side.y_neg) begin
            side.quad = QUAD_1;
        end else if (side.x_neg && !side.y_neg) begin
            side.quad = QUAD_2;
        end else if (side.x_neg && side.y_neg) begin
            side.quad = QUAD_3;
        end else begin
            side.quad = QUAD_4;
        end
        data_next.cx   = {{PAD_W{1'b0}}, ax, {FRAC_W{1'b0}}};
        data_next.cy   = {{PAD_W{1'b0}}, ay, {FRAC_W{1'b0}}};
        data_next.z    = '0;
        data_next.side = side;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/c2p_stage.sv =====
// one registered cordic vectoring iteration
module c2p_stage #(
    parameter int unsigned STAGE_IDX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  c2p_pkg::c2p_vec_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output c2p_pkg::c2p_vec_t  out_data
);
    import c2p_pkg::*;

    localparam logic signed [ANGLE_ACC_W-1:0] STEP_ANGLE = c2p_atan(STAGE_IDX);

    logic                     valid_reg;
    c2p_vec_t                 data_reg;
    c2p_vec_t                 data_next;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;

    always_comb begin
        dx = in_data.cy >>> STAGE_IDX;
        dy = in_data.cx >>> STAGE_IDX;
        data_next.side = in_data.side;
        // rotate toward the x axis by the sign of y
        if (!in_data.cy[DATA_W-1]) begin
            data_next.cx = in_data.cx + dx;
            data_next.cy = in_data.cy - dy;
            data_next.z  = in_data.z + STEP_ANGLE;
        end else begin
            data_next.cx = in_data.cx - dx;
            data_next.cy = in_data.cy + dy;
            data_next.z  = in_data.z - STEP_ANGLE;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/c2p_finish.sv =====
// gain correction and angle mapping, two stages ending in the output register
module c2p_finish (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  c2p_pkg::c2p_vec_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output c2p_pkg::c2p_out_t  out_data
);
    import c2p_pkg::*;

    localparam int unsigned MAG_W   = DATA_W - 1;
    localparam int unsigned LO_W    = MAG_W / 2;
    localparam int unsigned HI_W    = MAG_W - LO_W;
    localparam int unsigned PLO_W   = LO_W + GAIN_W;
    localparam int unsigned PHI_W   = HI_W + GAIN_W;
    localparam int unsigned SUM_W   = MAG_W + GAIN_W;
    localparam int unsigned RND_POS = FRAC_W + 23;
    localparam int unsigned FINE_W  = ANGLE_ACC_W - 1;
    localparam int unsigned A_W     = FINE_W - 8;

    // stage a: clamp, partial products, angle
    logic                       a_valid_reg;
    logic                       a_ready;
    logic [PLO_W-1:0]           plo_reg;
    logic [PHI_W-1:0]           phi_reg;
    logic [QUAD_W-1:0]          quad_reg;
    logic signed [ANGLE_W-1:0]  angle_reg;
    logic [MAG_W-1:0]           mag;
    logic [FINE_W-1:0]          zc;
    logic [FINE_W-1:0]          z_round;
    logic [A_W-1:0]             a;
    logic signed [ANGLE_W-1:0]  a_ext;
    logic signed [ANGLE_W-1:0]  half_minus;
    logic signed [ANGLE_W-1:0]  angle_next;

    // stage b: sum and round into the output register
    logic                       out_valid_reg;
    c2p_out_t                   out_reg;
    logic [SUM_W-1:0]           sum;

    always_comb begin
        mag = in_data.cx[DATA_W-1] ? '0 : in_data.cx[MAG_W-1:0];
        priority if (in_data.side.y_zero) begin
            zc = '0;
        end else if (in_data.side.x_zero) begin
            zc = FINE_W'(QUARTER_FINE);
        end else if (in_data.z[ANGLE_ACC_W-1]) begin
            zc = '0;
        end else if (in_data.z > ANGLE_ACC_W'(QUARTER_FINE)) begin
            zc = FINE_W'(QUARTER_FINE);
        end else begin
            zc = in_data.z[FINE_W-1:0];
        end
        z_round    = zc + FINE_W'(128);
        a          = z_round[FINE_W-1:8];
        a_ext      = ANGLE_W'(a);
        half_minus = ANGLE_W'(HALF_TURN) - a_ext;
        unique case ({in_data.side.x_neg, in_data.side.y_neg})
            2'b00:   angle_next = a_ext;
            2'b01:   angle_next = -a_ext;
            2'b10:   angle_next = half_minus;
            default: angle_next = -half_minus;
        endcase
    end

    assign a_ready  = !out_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            plo_reg   <= PLO_W'(mag[LO_W-1:0]) * PLO_W'(GAIN_Q24);
            phi_reg   <= PHI_W'(mag[MAG_W-1:LO_W]) * PHI_W'(GAIN_Q24);
            quad_reg  <= in_data.side.quad;
            angle_reg <= angle_next;
        end
    end

    assign sum = (SUM_W'(phi_reg) << LO_W) + SUM_W'(plo_reg) + (SUM_W'(1) << RND_POS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (a_ready) begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && a_valid_reg) begin
            out_reg.quadrant  <= quad_reg;
            out_reg.radius    <= sum[RND_POS+1 +: RADIUS_W];
            out_reg.angle_deg <= angle_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/cartesian_to_polar.sv =====
// Rectangular to polar converter, pipelined cordic vectoring.
// The s_ channel takes one point per transaction: coord_x and coord_y, signed
// integers. The m_ channel returns one result per point, in order: quadrant
// (1 to 4, 0 on an axis), radius rounded to whole units, and the atan2 angle
// in 1/128 degree from -23040 to +23040.
// From acceptance to m_valid a point passes one input stage, one register per
// cordic iteration, then a partial product stage and the output register. One
// point can be accepted every cycle unless a stall on m_ready has filled every
// stage; the throughput is set by the fully unrolled iteration chain.
// Every stage has its own valid bit and takes new data when it is empty or
// when its successor moves, so bubbles are squeezed out and the block keeps
// accepting points while a finished result waits on m_ready. When the
// receiver stalls with every stage full, s_ready drops; nothing is lost or
// repeated. Synchronous reset on aresetn clears all valid bits; the block
// accepts its first point in the cycle after reset is released.
module cartesian_to_polar #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  c2p_pkg::c2p_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output c2p_pkg::c2p_out_t  m_data
);
    import c2p_pkg::*;

    logic [CORDIC_STAGES:0] vec_valid;
    logic [CORDIC_STAGES:0] vec_ready;
    c2p_vec_t               vec_data [CORDIC_STAGES+1];

    c2p_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (vec_valid[0]),
        .out_ready (vec_ready[0]),
        .out_data  (vec_data[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        c2p_stage #(
            .STAGE_IDX (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vec_valid[i]),
            .in_ready  (vec_ready[i]),
            .in_data   (vec_data[i]),
            .out_valid (vec_valid[i+1]),
            .out_ready (vec_ready[i+1]),
            .out_data  (vec_data[i+1])
        );
    end

    c2p_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vec_valid[CORDIC_STAGES]),
        .in_ready  (vec_ready[CORDIC_STAGES]),
        .in_data   (vec_data[CORDIC_STAGES]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ===== hw/rtl/c2p_checker.sv =====
// port checker for the rectangular to polar converter and its bind
`include "assert_macros.svh"

module c2p_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input c2p_pkg::c2p_out_t  m_data
);
    import c2p_pkg::*;

    logic axis_angle_ok;
    logic upper_half;
    logic lower_half;
    logic angle_nonpos;

    assign axis_angle_ok = m_data.angle_deg == 16'sd0 || m_data.angle_deg == 16'sd11520 ||
                           m_data.angle_deg == -16'sd11520 || m_data.angle_deg == 16'sd23040;
    assign upper_half    = m_data.quadrant == QUAD_1 || m_data.quadrant == QUAD_2;
    assign lower_half    = m_data.quadrant == QUAD_3 || m_data.quadrant == QUAD_4;
    // a point just below the positive x axis can round to zero
    assign angle_nonpos  = m_data.angle_deg[ANGLE_W-1] || m_data.angle_deg == '0;

    // a stalled result holds
    `C2P_ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // reset empties the pipeline
    `C2P_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // points on an axis give only the four axis angles
    `C2P_ASSERT_RST(a_axis_angle, aclk, aresetn, m_valid && m_data.quadrant == QUAD_AXIS |-> axis_angle_ok)

    // upper half plane quadrants give a non-negative angle
    `C2P_ASSERT_RST(a_upper_angle, aclk, aresetn, m_valid && upper_half |-> !m_data.angle_deg[ANGLE_W-1])

    // lower half plane quadrants give an angle at or below zero
    `C2P_ASSERT_RST(a_lower_angle, aclk, aresetn, m_valid && lower_half |-> angle_nonpos)

endmodule

bind cartesian_to_polar c2p_checker u_c2p_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
